[hw/rtl/positional_array_insert_delete_minmax_macros.svh]
// Assertion macros used by the checker file of the positional array block.
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_MINMAX_MACROS_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_MINMAX_MACROS_SVH

// Same-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define POSAR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("posar: same-cycle check failed");

// Next-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define POSAR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("posar: next-cycle check failed");

`endif

[hw/rtl/posar_pkg.sv]
// Package of the positional array block: sizes, operation codes and transaction types.
package posar_pkg;

    // Array depth and the widths that follow from it.
    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [AW-1:0] SHIFT_TOP = AW'(DEPTH - 2);
    localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);
    localparam logic [8:0]    POS_LIMIT = 9'(DEPTH);

    // Operation codes.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    // Value constants.
    localparam logic signed [31:0] INT_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

    // Input transaction.
    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    // Result transaction.
    typedef struct packed {
        logic [4:0]         entry_count;
        logic signed [31:0] max_value;
        logic signed [31:0] min_value;
        logic               position_error;
    } t_out_item;

endpackage

[hw/rtl/posar_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module posar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/positional_array_insert_delete_minmax.sv]
// Top level of the positional array with insert, delete and running minimum and maximum.
//
//   Channel | Direction | Valid       | Stall        | Payload
//   --------+-----------+-------------+--------------+---------------------------
//   in      | to block  | i_in_valid  | o_in_stall   | i_in_data  (t_in_item)
//   out     | from block| o_out_valid | i_out_stall  | o_out_data (t_out_item)
//
// One operation is in flight at a time. A load scans the counted entries; an
// insert or delete first shifts the entries between its position and the end of the array
// and then scans, all of it paced by the single read port of the entry memory (one entry moved or scanned a cycle).
// Reset is synchronous and needs no clearing pass: a valid bit per entry makes an
// unwritten entry read as -1. A result waiting under i_out_stall does not block the
// next input transaction; only the hand-over of the following result waits for it.
module positional_array_insert_delete_minmax (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  posar_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output posar_pkg::t_out_item o_out_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    // Control registers.
    t_state                        r_state, n_state;
    logic [posar_pkg::DEPTH-1:0]   r_valid, n_valid;
    logic [posar_pkg::CW-1:0]      r_count, n_count;
    logic                          r_issue, n_issue;
    logic                          r_pend, n_pend;
    logic                          r_out_valid, n_out_valid;

    // Payload registers.
    logic [1:0]                    r_mode, n_mode;
    logic [posar_pkg::AW-1:0]      r_pos, n_pos;
    logic signed [31:0]            r_value, n_value;
    logic                          r_err, n_err;
    logic [posar_pkg::AW-1:0]      r_src, n_src;
    logic [posar_pkg::AW-1:0]      r_dst, n_dst;
    logic [posar_pkg::CW-1:0]      r_scan, n_scan;
    logic signed [31:0]            r_max, n_max;
    logic signed [31:0]            r_min, n_min;
    logic                          r_rd_valid;
    posar_pkg::t_out_item          r_out_data, n_out_data;

    // Memory port signals.
    logic                          wr_en;
    logic [posar_pkg::AW-1:0]      wr_addr;
    logic [31:0]                   wr_data;
    logic                          rd_en;
    logic [posar_pkg::AW-1:0]      rd_addr;
    logic [31:0]                   rd_data;

    logic                          accept;
    logic                          in_range;
    logic [posar_pkg::AW-1:0]      in_pos;
    logic signed [31:0]            entry;
    logic                          is_insert;
    logic [posar_pkg::AW-1:0]      shift_end;

    posar_ram #(
        .WIDTH (32),
        .DEPTH (posar_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign in_range  = {1'b0, i_in_data.position} < posar_pkg::POS_LIMIT;
    assign in_pos    = i_in_data.position[posar_pkg::AW-1:0];
    assign is_insert = (r_mode == posar_pkg::MODE_INSERT);
    assign shift_end = is_insert ? r_pos : posar_pkg::LAST_IDX;

    // An entry that was never written reads as -1.
    assign entry = r_rd_valid ? $signed(rd_data) : posar_pkg::EMPTY_VALUE;

    // Sequencer: accept, shift the entries, scan for the extremes, hand over the result.
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_count     = r_count;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_value     = r_value;
        n_err       = r_err;
        n_src       = r_src;
        n_dst       = r_dst;
        n_scan      = r_scan;
        n_max       = r_max;
        n_min       = r_min;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = r_value;
        rd_en       = 1'b0;
        rd_addr     = r_src;

        // The result register empties when the receiver takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                n_scan = '0;
                n_pend = 1'b0;
                n_max  = posar_pkg::INT_MIN;
                n_min  = posar_pkg::INT_MAX;
                if (accept) begin
                    n_mode  = i_in_data.mode;
                    n_pos   = in_pos;
                    n_value = i_in_data.value;
                    n_err   = 1'b0;
                    n_issue = 1'b0;
                    n_state = ST_SCAN;
                    unique case (i_in_data.mode)
                        posar_pkg::MODE_LOAD: begin
                            if (in_range) begin
                                wr_en   = 1'b1;
                                wr_addr = in_pos;
                                wr_data = i_in_data.value;
                                n_count = posar_pkg::CW'(in_pos) + posar_pkg::CW'(1);
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        posar_pkg::MODE_INSERT: begin
                            if (in_range) begin
                                n_state = ST_SHIFT;
                                n_issue = (in_pos != posar_pkg::LAST_IDX);
                                n_src   = posar_pkg::SHIFT_TOP;
                                if (r_count != posar_pkg::COUNT_MAX) begin
                                    n_count = r_count + posar_pkg::CW'(1);
                                end
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        posar_pkg::MODE_DELETE: begin
                            if (in_range) begin
                                n_state = ST_SHIFT;
                                n_issue = (in_pos != posar_pkg::LAST_IDX);
                                n_src   = in_pos + posar_pkg::AW'(1);
                                if (r_count != '0) begin
                                    n_count = r_count - posar_pkg::CW'(1);
                                end
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        default: begin
                            // The unused code changes nothing and reports no error.
                        end
                    endcase
                end
            end

            ST_SHIFT: begin
                // Read one source entry a cycle; write it one slot over in the cycle after its read.
                rd_en  = r_issue;
                n_pend = r_issue;
                n_dst  = is_insert ? r_src + posar_pkg::AW'(1) : r_src - posar_pkg::AW'(1);
                if (r_issue) begin
                    if (r_src == shift_end) begin
                        n_issue = 1'b0;
                    end else begin
                        n_src = is_insert ? r_src - posar_pkg::AW'(1)
                                          : r_src + posar_pkg::AW'(1);
                    end
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_dst;
                    wr_data = entry;
                end else if (!r_issue) begin
                    // Shift drained: an insert now places its value at the position.
                    wr_en   = is_insert;
                    wr_addr = r_pos;
                    wr_data = r_value;
                    n_state = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Stream the first count entries through the extreme-value compare.
                if (r_scan != r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_scan[posar_pkg::AW-1:0];
                    n_scan  = r_scan + posar_pkg::CW'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (entry > r_max) begin
                        n_max = entry;
                    end
                    if ((entry != posar_pkg::EMPTY_VALUE) && (entry < r_min)) begin
                        n_min = entry;
                    end
                end else if (r_scan == r_count) begin
                    n_state = ST_OUT;
                end
            end

            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid                = 1'b1;
                    n_out_data.entry_count     = 5'(r_count);
                    n_out_data.max_value       = r_max;
                    n_out_data.min_value       = r_min;
                    n_out_data.position_error  = r_err;
                    n_state                    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Every written entry becomes valid.
        if (wr_en) begin
            n_valid[wr_addr] = 1'b1;
        end
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_pos      <= n_pos;
        r_value    <= n_value;
        r_err      <= n_err;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_scan     <= n_scan;
        r_max      <= n_max;
        r_min      <= n_min;
        r_out_data <= n_out_data;
        if (rd_en) begin
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hw/rtl/posar_chk.sv]
// Port-level checker for the positional array block, bound to its top level.
`include "positional_array_insert_delete_minmax_macros.svh"

module posar_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input posar_pkg::t_in_item  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input posar_pkg::t_out_item o_out_data
);

    // A stalled result holds its value.
    `POSAR_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // One operation at a time: the block is busy right after a transaction is taken.
    `POSAR_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // An empty array reports the neutral extremes.
    `POSAR_ASSERT_IMP(a_empty_extremes, o_out_valid && (o_out_data.entry_count == 5'd0) && (posar_pkg::DEPTH < 32), (o_out_data.max_value == posar_pkg::INT_MIN) && (o_out_data.min_value == posar_pkg::INT_MAX))

    // The minimum never reports the empty marker.
    `POSAR_ASSERT_IMP(a_min_not_empty, o_out_valid, o_out_data.min_value != posar_pkg::EMPTY_VALUE)

endmodule

bind positional_array_insert_delete_minmax posar_chk u_posar_chk (.*);

[verif/posar_minmax_checker.sv]
// Checker for the positional array block: predicts each result and compares it.
`timescale 1ns / 100ps

module posar_minmax_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  posar_pkg::t_in_item  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  posar_pkg::t_out_item i_out_data,
    output int unsigned          o_error_count,
    output int unsigned          o_pending
);

    // Predicted copy of the array contents and of the element count.
    logic signed [31:0] array_image [posar_pkg::DEPTH];
    int unsigned        array_count;
    int unsigned        failures = 0;

    // Results predicted for accepted operations, oldest first.
    posar_pkg::t_out_item pending_results [$];

    // Return the predicted array to its state after reset.
    function automatic void clear_array_image();
        for (int i = 0; i < posar_pkg::DEPTH; i++) begin
            array_image[i] = posar_pkg::EMPTY_VALUE;
        end
        array_count = 0;
    endfunction

    // Apply one operation to the predicted array and work out its result.
    function automatic posar_pkg::t_out_item apply_array_op(input posar_pkg::t_in_item op);
        posar_pkg::t_out_item res;
        int unsigned          pos;
        logic signed [31:0]   largest;
        logic signed [31:0]   smallest;
        pos = op.position;
        res.position_error = 1'b0;
        if (op.mode == posar_pkg::MODE_LOAD || op.mode == posar_pkg::MODE_INSERT ||
            op.mode == posar_pkg::MODE_DELETE) begin
            if (pos >= posar_pkg::DEPTH) begin
                // An out-of-range position is rejected and leaves everything as it was.
                res.position_error = 1'b1;
            end else if (op.mode == posar_pkg::MODE_LOAD) begin
                array_image[pos] = op.value;
                array_count = pos + 1;
            end else if (op.mode == posar_pkg::MODE_INSERT) begin
                // Shift upward from the position; the top entry falls off.
                for (int i = posar_pkg::DEPTH - 1; i > int'(pos); i--) begin
                    array_image[i] = array_image[i - 1];
                end
                array_image[pos] = op.value;
                if (array_count < posar_pkg::DEPTH) begin
                    array_count++;
                end
            end else begin
                // Shift downward onto the position; the top entry keeps its value.
                for (int i = int'(pos); i < posar_pkg::DEPTH - 1; i++) begin
                    array_image[i] = array_image[i + 1];
                end
                if (array_count > 0) begin
                    array_count--;
                end
            end
        end
        // Scan the counted entries; the minimum skips the empty marker.
        largest  = posar_pkg::INT_MIN;
        smallest = posar_pkg::INT_MAX;
        for (int i = 0; i < int'(array_count); i++) begin
            if (array_image[i] > largest) begin
                largest = array_image[i];
            end
            if (array_image[i] != posar_pkg::EMPTY_VALUE && array_image[i] < smallest) begin
                smallest = array_image[i];
            end
        end
        res.entry_count = 5'(array_count);
        res.max_value   = largest;
        res.min_value   = smallest;
        return res;
    endfunction

    // Report one field that differs from its prediction.
    task automatic compare_field(input string field, input logic signed [32:0] want,
                                 input logic signed [32:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
            failures++;
        end
    endtask

    // Check results against the oldest prediction, then predict for new operations.
    always @(posedge i_clk) begin : result_check
        posar_pkg::t_out_item want;
        if (!i_rst_n) begin
            clear_array_image();
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual %p",
                             $time, i_out_data);
                    failures++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("entry_count", want.entry_count, i_out_data.entry_count);
                    compare_field("max_value", want.max_value, i_out_data.max_value);
                    compare_field("min_value", want.min_value, i_out_data.min_value);
                    compare_field("position_error", want.position_error,
                                  i_out_data.position_error);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(apply_array_op(i_in_data));
            end
        end
        o_pending     <= pending_results.size();
        o_error_count <= failures;
    end

endmodule

[verif/tb_positional_array_insert_delete_minmax.sv]
// Testbench top for the positional array block: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module tb_positional_array_insert_delete_minmax;

    localparam int CLK_PERIOD     = 20;
    localparam int RANDOM_OPS     = 530;
    localparam int HOLD_AFTER_OPS = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 4000;

    // The fourth code is not an operation; the block must leave its state alone.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    posar_pkg::t_in_item  in_data;
    logic                 out_valid;
    logic                 out_stall;
    posar_pkg::t_out_item out_data;
    int unsigned          error_count;
    int unsigned          pending;
    int unsigned          ops_sent;
    int unsigned          burst_left;
    int unsigned          quiet_cycles;

    positional_array_insert_delete_minmax u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    posar_minmax_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Give up when neither channel has moved a transaction for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired after %0d idle cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result-side stall: segments of differing stall density, plus one long hold-off
    // while the sender keeps offering, so that the block backs up onto its input.
    initial begin : result_stall_gen
        int unsigned seg_len;
        int unsigned stall_pct;
        bit          held_off;
        held_off  = 1'b0;
        out_stall <= 1'b0;
        forever begin
            if (!held_off && ops_sent >= HOLD_AFTER_OPS) begin
                held_off = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end else begin
                seg_len = $urandom_range(8, 64);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                repeat (seg_len) begin
                    @(negedge clk);
                    out_stall <= ($urandom_range(0, 99) < stall_pct);
                end
            end
        end
    end

    function automatic posar_pkg::t_in_item mk_op(input logic [1:0] op_mode,
                                                  input logic [7:0] pos,
                                                  input logic signed [31:0] val);
        posar_pkg::t_in_item op;
        op.mode     = op_mode;
        op.position = pos;
        op.value    = val;
        return op;
    endfunction

    // Offer one operation and hold it until the block takes it.
    task automatic send_op(input posar_pkg::t_in_item op);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= op;
        do begin
            @(posedge clk);
        end while (in_stall);
        ops_sent++;
    endtask

    // Send with burst pacing: a random gap follows each burst of random length.
    task automatic send_paced(input posar_pkg::t_in_item op);
        int unsigned gap;
        send_op(op);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(0, 23);
        end
    endtask

    // Reset, directed operations, random operations, then drain and verdict.
    initial begin : stimulus
        logic [1:0]         op_mode;
        logic [7:0]         pos;
        logic signed [31:0] val;
        int unsigned        pick;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        ops_sent   = 0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Unused code on the reset state, then a delete with nothing counted.
        send_paced(mk_op(MODE_UNUSED, 8'd0, 32'sd0));
        send_paced(mk_op(posar_pkg::MODE_DELETE, 8'd0, 32'sd0));
        // Extreme values, and an empty marker that the minimum must skip.
        send_paced(mk_op(posar_pkg::MODE_LOAD, 8'd0, posar_pkg::INT_MAX));
        send_paced(mk_op(posar_pkg::MODE_INSERT, 8'd0, posar_pkg::INT_MIN));
        send_paced(mk_op(posar_pkg::MODE_INSERT, 8'd1, posar_pkg::EMPTY_VALUE));
        // Load at the last position fills the count; inserts then saturate it.
        send_paced(mk_op(posar_pkg::MODE_LOAD, 8'd15, 32'sd0));
        send_paced(mk_op(posar_pkg::MODE_INSERT, 8'd0, 32'sh5555_5555));
        send_paced(mk_op(posar_pkg::MODE_INSERT, 8'd15, 32'shAAAA_AAAA));
        send_paced(mk_op(posar_pkg::MODE_DELETE, 8'd15, 32'sd0));
        send_paced(mk_op(posar_pkg::MODE_DELETE, 8'd0, 32'sd0));
        // Rejected positions for every operation, and the unused code with all ones.
        send_paced(mk_op(posar_pkg::MODE_LOAD, 8'd16, 32'sd9));
        send_paced(mk_op(posar_pkg::MODE_INSERT, 8'd255, 32'sd9));
        send_paced(mk_op(posar_pkg::MODE_DELETE, 8'd128, 32'sd0));
        send_paced(mk_op(posar_pkg::MODE_LOAD, 8'd31, posar_pkg::EMPTY_VALUE));
        send_paced(mk_op(MODE_UNUSED, 8'd255, posar_pkg::INT_MIN));
        // A low load shrinks the count; deletes then run it down to zero, where it stays.
        send_paced(mk_op(posar_pkg::MODE_LOAD, 8'd3, 32'sd7));
        repeat (5) send_paced(mk_op(posar_pkg::MODE_DELETE, 8'd0, 32'sd0));
        // Only empty markers counted: the minimum has nothing to report.
        send_paced(mk_op(posar_pkg::MODE_LOAD, 8'd0, posar_pkg::EMPTY_VALUE));

        // Random operations, weighted towards inserts so the array fills up.
        repeat (RANDOM_OPS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                op_mode = MODE_UNUSED;
            end else if (pick < 30) begin
                op_mode = posar_pkg::MODE_LOAD;
            end else if (pick < 72) begin
                op_mode = posar_pkg::MODE_INSERT;
            end else begin
                op_mode = posar_pkg::MODE_DELETE;
            end
            if ($urandom_range(0, 9) == 0) begin
                pos = 8'($urandom_range(posar_pkg::DEPTH, 255));
            end else begin
                pos = 8'($urandom_range(0, posar_pkg::DEPTH - 1));
            end
            case ($urandom_range(0, 9))
                0: val = posar_pkg::EMPTY_VALUE;
                1: val = posar_pkg::INT_MIN;
                2: val = posar_pkg::INT_MAX;
                3, 4, 5: val = $signed(32'($urandom_range(0, 200))) - 32'sd100;
                default: val = $urandom;
            endcase
            send_paced(mk_op(op_mode, pos, val));
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
